// ----- rtl/char_lcd_nibble_writer_assert.svh -----
// assertion macros for the lcd nibble writer checker
`ifndef CHAR_LCD_NIBBLE_WRITER_ASSERT_SVH
`define CHAR_LCD_NIBBLE_WRITER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CLNW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CLNW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/clnw_pkg.sv -----
`default_nettype none

package clnw_pkg;

    typedef enum logic [1:0] {
        OP_CMD  = 2'd0,
        OP_CHAR = 2'd1,
        OP_NUM  = 2'd2,
        OP_INIT = 2'd3
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] value;
    } cmd_word_t;

    typedef struct packed {
        logic       rs;
        logic [3:0] nibble;
        logic [4:0] wait_ms;
        logic       last;
    } xfer_word_t;

    // step counter and program addresses
    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t PC_HOME     = 4'd0;
    localparam pc_t PC_BYTE_HI  = 4'd1;
    localparam pc_t PC_BYTE_LO  = 4'd2;
    localparam pc_t PC_DIV_MUL  = 4'd3;
    localparam pc_t PC_DIV_PUSH = 4'd4;
    localparam pc_t PC_DIG_HI   = 4'd5;
    localparam pc_t PC_DIG_LO   = 4'd6;
    localparam pc_t PC_INIT_HI  = 4'd7;
    localparam pc_t PC_INIT_LO  = 4'd8;

    typedef enum logic [2:0] {
        NSRC_BYTE_HI,
        NSRC_BYTE_LO,
        NSRC_ASCII_HI,
        NSRC_DIGIT,
        NSRC_INIT_HI,
        NSRC_INIT_LO
    } nsrc_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_MUL,
        ACT_PUSH,
        ACT_POP,
        ACT_INIT_NEXT
    } act_t;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_GOTO,
        COND_DISPATCH,
        COND_MORE_NEXT,
        COND_MORE_HOME
    } cond_t;

    typedef enum logic [1:0] {
        FLAG_DIV,
        FLAG_DIGIT,
        FLAG_INIT
    } flag_sel_t;

    typedef enum logic [1:0] {
        LAST_NO,
        LAST_YES,
        LAST_DONE
    } last_sel_t;

    // one control word of the program
    typedef struct packed {
        logic      emit;
        nsrc_t     nsrc;
        logic      wait_en;
        last_sel_t last_sel;
        act_t      act;
        cond_t     cond;
        flag_sel_t flag_sel;
        pc_t       target;
    } ctrl_t;

    // sequencer to datapath
    typedef struct packed {
        logic  fire;
        logic  emit;
        act_t  act;
        nsrc_t nsrc;
        logic  wait_en;
        logic  last;
    } dp_ctl_t;

    // datapath to sequencer
    typedef struct packed {
        logic div_more;
        logic digit_more;
        logic init_more;
    } flags_t;

    localparam int INIT_LEN = 10;
    typedef logic [3:0] init_idx_t;
    localparam init_idx_t INIT_LAST = init_idx_t'(INIT_LEN - 1);

    localparam logic [4:0] WAIT_WAKE_MS = 5'd4;
    localparam logic [4:0] WAIT_END_MS  = 5'd20;

    // floor(v / 10) = (v * RECIP_10) >> RECIP_SHIFT for any 32-bit v
    localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;
    localparam int          QUOT_W      = 64 - RECIP_SHIFT;

    // high nibble of ascii '0'..'9'
    localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;

    function automatic logic [7:0] init_byte(input init_idx_t idx);
        logic [7:0] b;
        unique case (idx)
            4'd0, 4'd1, 4'd2: b = 8'h03;
            4'd3:             b = 8'h02;
            4'd4:             b = 8'h28;
            4'd5:             b = 8'h08;
            4'd6, 4'd8:       b = 8'h01;
            4'd7:             b = 8'h06;
            4'd9:             b = 8'h0C;
            default:          b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [4:0] init_wait(input init_idx_t idx);
        logic [4:0] w;
        unique case (idx)
            4'd0, 4'd1, 4'd2: w = WAIT_WAKE_MS;
            4'd9:             w = WAIT_END_MS;
            default:          w = 5'd0;
        endcase
        return w;
    endfunction

    // control store
    function automatic ctrl_t ucode(input pc_t pc);
        ctrl_t cw;
        cw = '0;
        cw.nsrc     = NSRC_BYTE_HI;
        cw.last_sel = LAST_NO;
        cw.act      = ACT_NONE;
        cw.cond     = COND_NEXT;
        cw.flag_sel = FLAG_DIV;
        cw.target   = PC_HOME;
        unique case (pc)
            PC_HOME: begin
                cw.act  = ACT_LOAD;
                cw.cond = COND_DISPATCH;
            end
            PC_BYTE_HI: begin
                cw.emit = 1'b1;
                cw.nsrc = NSRC_BYTE_HI;
            end
            PC_BYTE_LO: begin
                cw.emit     = 1'b1;
                cw.nsrc     = NSRC_BYTE_LO;
                cw.last_sel = LAST_YES;
                cw.cond     = COND_GOTO;
            end
            PC_DIV_MUL: begin
                cw.act = ACT_MUL;
            end
            PC_DIV_PUSH: begin
                cw.act      = ACT_PUSH;
                cw.cond     = COND_MORE_NEXT;
                cw.flag_sel = FLAG_DIV;
                cw.target   = PC_DIV_MUL;
            end
            PC_DIG_HI: begin
                cw.emit = 1'b1;
                cw.nsrc = NSRC_ASCII_HI;
            end
            PC_DIG_LO: begin
                cw.emit     = 1'b1;
                cw.nsrc     = NSRC_DIGIT;
                cw.act      = ACT_POP;
                cw.last_sel = LAST_DONE;
                cw.cond     = COND_MORE_HOME;
                cw.flag_sel = FLAG_DIGIT;
                cw.target   = PC_DIG_HI;
            end
            PC_INIT_HI: begin
                cw.emit = 1'b1;
                cw.nsrc = NSRC_INIT_HI;
            end
            PC_INIT_LO: begin
                cw.emit     = 1'b1;
                cw.nsrc     = NSRC_INIT_LO;
                cw.wait_en  = 1'b1;
                cw.act      = ACT_INIT_NEXT;
                cw.last_sel = LAST_DONE;
                cw.cond     = COND_MORE_HOME;
                cw.flag_sel = FLAG_INIT;
                cw.target   = PC_INIT_HI;
            end
            default: begin
                cw.cond = COND_GOTO;
            end
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/clnw_seq.sv -----
`default_nettype none

module clnw_seq (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire clnw_pkg::op_t    op,
    input  wire logic             cmd_valid,
    output logic                  cmd_stall,
    input  wire logic             out_free,
    input  wire clnw_pkg::flags_t flags,
    output clnw_pkg::dp_ctl_t     ctl
);
    import clnw_pkg::*;

    pc_t   pc_reg;
    pc_t   pc_next;
    pc_t   pc_dispatch;
    ctrl_t cw;
    logic  flag;
    logic  fire;

    assign cw = ucode(pc_reg);

    always_comb
    begin
        unique case (cw.flag_sel)
            FLAG_DIV:   flag = flags.div_more;
            FLAG_DIGIT: flag = flags.digit_more;
            FLAG_INIT:  flag = flags.init_more;
            default:    flag = 1'b0;
        endcase
    end

    always_comb
    begin
        unique case (op)
            OP_CMD, OP_CHAR: pc_dispatch = PC_BYTE_HI;
            OP_NUM:          pc_dispatch = PC_DIV_MUL;
            OP_INIT:         pc_dispatch = PC_INIT_HI;
        endcase
    end

    // only the home step takes a new word
    assign cmd_stall = (cw.cond != COND_DISPATCH);

    always_comb
    begin
        if (cw.cond == COND_DISPATCH)
            fire = cmd_valid;
        else if (cw.emit)
            fire = out_free;
        else
            fire = 1'b1;
    end

    always_comb
    begin
        pc_next = pc_reg;
        if (fire)
        begin
            unique case (cw.cond)
                COND_NEXT:      pc_next = pc_reg + pc_t'(1);
                COND_GOTO:      pc_next = cw.target;
                COND_DISPATCH:  pc_next = pc_dispatch;
                COND_MORE_NEXT: pc_next = flag ? cw.target : pc_reg + pc_t'(1);
                COND_MORE_HOME: pc_next = flag ? cw.target : PC_HOME;
                default:        pc_next = PC_HOME;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= PC_HOME;
        else
            pc_reg <= pc_next;
    end

    always_comb
    begin
        ctl.fire    = fire;
        ctl.emit    = cw.emit;
        ctl.act     = cw.act;
        ctl.nsrc    = cw.nsrc;
        ctl.wait_en = cw.wait_en;
        ctl.last    = (cw.last_sel == LAST_YES) || ((cw.last_sel == LAST_DONE) && !flag);
    end

endmodule

`default_nettype wire

// ----- rtl/clnw_dp.sv -----
`default_nettype none

module clnw_dp #(
    parameter int MAX_DIGITS = 10
) (
    input  wire logic                clk,
    input  wire clnw_pkg::dp_ctl_t   ctl,
    input  wire clnw_pkg::cmd_word_t cmd_word,
    output clnw_pkg::flags_t         flags,
    output clnw_pkg::xfer_word_t     xfer_next
);
    import clnw_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    logic [31:0]       value_reg;
    logic [QUOT_W-1:0] q_reg;
    logic              rs_reg;
    logic [CNT_W-1:0]  cnt_reg;
    init_idx_t         idx_reg;
    logic [3:0]        digits_reg [MAX_DIGITS];

    logic [63:0]       prod;
    logic [31:0]       q_times_10;
    logic [31:0]       rem;
    logic [CNT_W-1:0]  cnt_inc;
    logic [CNT_W-1:0]  cnt_dec;
    logic [7:0]        init_b;

    // reciprocal multiply, quotient registered before the subtract step
    assign prod       = 64'(value_reg) * 64'(RECIP_10);
    assign q_times_10 = 32'({q_reg, 3'b000}) + 32'({q_reg, 1'b0});
    assign rem        = value_reg - q_times_10;
    assign cnt_inc    = cnt_reg + CNT_W'(1);
    assign cnt_dec    = cnt_reg - CNT_W'(1);
    assign init_b     = init_byte(idx_reg);

    always_comb
    begin
        flags.div_more   = (q_reg != '0) && (cnt_inc < CNT_W'(MAX_DIGITS));
        flags.digit_more = (cnt_reg != CNT_W'(1));
        flags.init_more  = (idx_reg != INIT_LAST);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.fire)
        begin
            case (ctl.act)
                ACT_LOAD: begin
                    value_reg <= cmd_word.value;
                    rs_reg    <= (cmd_word.op == OP_CHAR) || (cmd_word.op == OP_NUM);
                    cnt_reg   <= '0;
                    idx_reg   <= '0;
                end
                ACT_MUL: begin
                    q_reg <= prod[63:RECIP_SHIFT];
                end
                ACT_PUSH: begin
                    digits_reg[cnt_reg[IDX_W-1:0]] <= rem[3:0];
                    cnt_reg   <= cnt_inc;
                    value_reg <= 32'(q_reg);
                end
                ACT_POP: begin
                    cnt_reg <= cnt_dec;
                end
                ACT_INIT_NEXT: begin
                    idx_reg <= idx_reg + init_idx_t'(1);
                end
                default: begin
                end
            endcase
        end
    end

    always_comb
    begin
        xfer_next.rs      = rs_reg;
        xfer_next.wait_ms = ctl.wait_en ? init_wait(idx_reg) : 5'd0;
        xfer_next.last    = ctl.last;
        case (ctl.nsrc)
            NSRC_BYTE_HI:  xfer_next.nibble = value_reg[7:4];
            NSRC_BYTE_LO:  xfer_next.nibble = value_reg[3:0];
            NSRC_ASCII_HI: xfer_next.nibble = ASCII_DIGIT_HI;
            NSRC_DIGIT:    xfer_next.nibble = digits_reg[cnt_dec[IDX_W-1:0]];
            NSRC_INIT_HI:  xfer_next.nibble = init_b[7:4];
            NSRC_INIT_LO:  xfer_next.nibble = init_b[3:0];
            default:       xfer_next.nibble = 4'h0;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/char_lcd_nibble_writer.sv -----
// Character LCD nibble writer for a 4-bit HD44780-style bus. Each command word
// (op, value) becomes a run of transfer words, one per enable strobe: rs, the
// nibble for D7..D4 (high nibble first), the wait in ms to apply after the
// strobe, and last on the final transfer of the request. op selects a command
// byte (rs=0), a character byte (rs=1), an unsigned number sent as ascii
// decimal digits most significant first (rs=1, zero gives '0', only the
// MAX_DIGITS low digits are kept), or the ten-byte power-up list with 4 ms
// after each wake-up byte and 20 ms at the very end. One request is handled
// at a time: cmd_stall is low only while the sequencer sits at its home step.
// A number request runs one division step pair per digit through the shared
// reciprocal multiplier before its digits go out, and every request passes its
// nibbles through the single transfer register, which takes one nibble per
// cycle while the transfer side does not stall.
`default_nettype none

module char_lcd_nibble_writer #(
    parameter int MAX_DIGITS = 10
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cmd_valid,
    output logic                      cmd_stall,
    input  wire clnw_pkg::cmd_word_t  cmd_word,
    output logic                      xfer_valid,
    input  wire logic                 xfer_stall,
    output clnw_pkg::xfer_word_t      xfer_word
);
    import clnw_pkg::*;

    // sequencer / datapath links
    dp_ctl_t    ctl;
    flags_t     flags;
    xfer_word_t xfer_next;

    // transfer output register
    logic       xfer_valid_reg;
    xfer_word_t xfer_word_reg;
    logic       out_free;
    logic       load_out;

    // microcoded step counter: fetches a control word per step and jumps
    clnw_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (cmd_word.op),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .out_free  (out_free),
        .flags     (flags),
        .ctl       (ctl)
    );

    // value, quotient, digit stack and init index, plus nibble select
    clnw_dp #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .clk       (clk),
        .ctl       (ctl),
        .cmd_word  (cmd_word),
        .flags     (flags),
        .xfer_next (xfer_next)
    );

    // register is free when empty or being drained this cycle
    assign out_free = !xfer_valid_reg || !xfer_stall;
    assign load_out = ctl.fire && ctl.emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            xfer_valid_reg <= 1'b0;
        else if (load_out)
            xfer_valid_reg <= 1'b1;
        else if (!xfer_stall)
            xfer_valid_reg <= 1'b0;
    end

    // payload holds while stalled, since load_out needs out_free
    always_ff @(posedge clk)
    begin
        if (load_out)
            xfer_word_reg <= xfer_next;
    end

    assign xfer_valid = xfer_valid_reg;
    assign xfer_word  = xfer_word_reg;

endmodule

`default_nettype wire

// ----- rtl/clnw_checker.sv -----
`default_nettype none

`include "char_lcd_nibble_writer_assert.svh"

module clnw_checker (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 cmd_valid,
    input wire logic                 cmd_stall,
    input wire logic                 xfer_valid,
    input wire logic                 xfer_stall,
    input wire clnw_pkg::xfer_word_t xfer_word
);

    // a stalled transfer word stays put
    `CLNW_ASSERT_NEXT(a_xfer_hold, xfer_valid && xfer_stall, xfer_valid && $stable(xfer_word), "transfer word changed under stall")

    // one request at a time: busy right after a command word is taken
    `CLNW_ASSERT_NEXT(a_busy_after_cmd, cmd_valid && !cmd_stall, cmd_stall, "second command word taken while busy")

    `CLNW_ASSERT_NOW(a_wait_codes, xfer_valid, (xfer_word.wait_ms == 5'd0) || (xfer_word.wait_ms == 5'd4) || (xfer_word.wait_ms == 5'd20), "wait_ms outside 0, 4, 20")

    // waits only come with the init list, which is all commands
    `CLNW_ASSERT_NOW(a_wait_cmd_only, xfer_valid && (xfer_word.wait_ms != 5'd0), !xfer_word.rs, "wait on a data transfer")

    `CLNW_ASSERT_NOW(a_long_wait_last, xfer_valid && (xfer_word.wait_ms == 5'd20), xfer_word.last, "20 ms wait not on final transfer")

endmodule

bind char_lcd_nibble_writer clnw_checker u_clnw_checker (.*);

`default_nettype wire
